@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle check, clocked on clk, off during reset
`define ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle check
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/tcs_pkg.sv @@
`default_nettype none

package tcs_pkg;

    localparam int COORD_W  = 24;
    localparam int FRAC_W   = 16;
    localparam int ANG_FRAC = 24;
    localparam int CFG_W    = 24;
    localparam int REG_W    = 23;
    localparam int YAW_W    = FRAC_W + 3;
    localparam int IDX_W    = 3;

    localparam int CORDIC_N = 24;
    localparam int CRD_STG  = CORDIC_N / 2;
    localparam int CORD_W   = 28;
    localparam int ANG_W    = 28;
    localparam int GAIN_SH  = 28;
    localparam int MUL_W    = CORD_W + GAIN_SH + 1;
    localparam int LOC_W    = 27;
    localparam int DIST_W   = 28;
    localparam int SUM_W    = 29;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int SQ_IN_W  = 52;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int SQ_REM_W = SQ_OUT_W + 2;
    localparam int SQ_STG   = SQ_OUT_W / 2;
    localparam int NUM_LEGS = 4;

    // delay line lengths around the two root pipelines
    localparam int PZ_N   = CRD_STG + 4;
    localparam int MTOP_N = SQ_STG + 2;
    localparam int DV_N   = SQ_STG + 4;
    localparam int MLEG_N = SQ_STG + 2;
    localparam int DTOP_N = SQ_STG + 4;
    localparam int LAT    = CRD_STG + 2 * SQ_STG + 13;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q = 28'sd26353589;
    localparam logic signed [GAIN_SH:0] GAIN_Q    = 29'sd163008219;
    localparam logic signed [MUL_W-1:0] GAIN_RND  = MUL_W'(1 << (GAIN_SH - 1));

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(1 << (COORD_W - 1)));

    localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_N] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
        28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768, 28'sd16384,
        28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512, 28'sd256, 28'sd128,
        28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2
    };

    // leg corner offsets taken with minus sign: (+,+) (-,+) (-,-) (+,-)
    localparam logic [NUM_LEGS-1:0] CORNER_NEG_X = 4'b0110;
    localparam logic [NUM_LEGS-1:0] CORNER_NEG_Y = 4'b1100;

    typedef enum logic [IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_TABLE_HEIGHT,
        REG_TOP_WIDTH,
        REG_TOP_DEPTH,
        REG_YAW_ANGLE,
        REG_LEG_RADIUS,
        REG_TOP_THICKNESS
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PART_TOP,
        PART_LEG_A,
        PART_LEG_B,
        PART_LEG_C,
        PART_LEG_D
    } part_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] dist_top;
        logic signed [COORD_W-1:0] dist_leg_a;
        logic signed [COORD_W-1:0] dist_leg_b;
        logic signed [COORD_W-1:0] dist_leg_c;
        logic signed [COORD_W-1:0] dist_leg_d;
        logic signed [COORD_W-1:0] dist_union;
        part_t                     nearest_part;
    } sdf_t;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ANG_W-1:0]  th;
    } rot_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_OUT_W-1:0] root;
    } sq_state_t;

    function automatic rot_t pre_rot(input rot_t s);
        rot_t o;
        o = s;
        if (s.th > HALF_PI_Q)
        begin
            o.x  = -s.y;
            o.y  = s.x;
            o.th = s.th - HALF_PI_Q;
        end
        else if (s.th < -HALF_PI_Q)
        begin
            o.x  = s.y;
            o.y  = -s.x;
            o.th = s.th + HALF_PI_Q;
        end
        return o;
    endfunction

    function automatic rot_t cordic_it(input rot_t s, input logic [4:0] i);
        logic signed [CORD_W-1:0] xs;
        logic signed [CORD_W-1:0] ys;
        rot_t o;
        xs = s.x >>> i;
        ys = s.y >>> i;
        if (!s.th[ANG_W-1])
        begin
            o.x  = s.x - ys;
            o.y  = s.y + xs;
            o.th = s.th - ATAN_TAB[i];
        end
        else
        begin
            o.x  = s.x + ys;
            o.y  = s.y - xs;
            o.th = s.th + ATAN_TAB[i];
        end
        return o;
    endfunction

    // one restoring root digit
    function automatic sq_state_t sq_step(input sq_state_t s, input logic [1:0] pair);
        logic [SQ_REM_W+1:0] r2;
        logic [SQ_REM_W+1:0] trial;
        sq_state_t o;
        r2    = {s.rem, pair};
        trial = (SQ_REM_W + 2)'({s.root, 2'b01});
        if (r2 >= trial)
        begin
            o.rem  = SQ_REM_W'(r2 - trial);
            o.root = {s.root[SQ_OUT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = SQ_REM_W'(r2);
            o.root = {s.root[SQ_OUT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic signed [DIST_W-1:0] abs_d(input logic signed [DIST_W-1:0] v);
        return v[DIST_W-1] ? -v : v;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_u(input logic signed [DIST_W-1:0] v);
        if (v <= 0)
            return '0;
        else if (v[DIST_W-1:COORD_W] != '0)
            return '1;
        else
            return v[COORD_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_d(input logic signed [SUM_W-1:0] v);
        if (v > SAT_HI)
            return SAT_HI[COORD_W-1:0];
        else if (v < SAT_LO)
            return SAT_LO[COORD_W-1:0];
        else
            return v[COORD_W-1:0];
    endfunction

    function automatic logic signed [DIST_W-1:0] min0(input logic signed [DIST_W-1:0] v);
        return v[DIST_W-1] ? v : '0;
    endfunction

endpackage

`default_nettype wire

@@ sv/tcs_isqrt.sv @@
`default_nettype none

module tcs_isqrt
    import tcs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [SQ_IN_W-1:0]  rad,
    output logic      [SQ_OUT_W-1:0] root
);

    logic [SQ_REM_W-1:0] rem_reg  [SQ_STG];
    logic [SQ_OUT_W-1:0] root_reg [SQ_STG];
    logic [SQ_IN_W-1:0]  rad_reg  [SQ_STG];

    // two root bits per stage, radicand consumed from the top
    for (genvar k = 0; k < SQ_STG; k++)
    begin : g_stg
        sq_state_t          s_in;
        sq_state_t          s_mid;
        sq_state_t          s_out;
        logic [SQ_IN_W-1:0] r_in;

        if (k == 0)
        begin : g_first
            assign s_in = '0;
            assign r_in = rad;
        end
        else
        begin : g_next
            assign s_in = '{rem: rem_reg[k-1], root: root_reg[k-1]};
            assign r_in = rad_reg[k-1];
        end

        assign s_mid = sq_step(s_in, r_in[SQ_IN_W-1 -: 2]);
        assign s_out = sq_step(s_mid, r_in[SQ_IN_W-3 -: 2]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= s_out.rem;
                root_reg[k] <= s_out.root;
                rad_reg[k]  <= r_in << 4;
            end
        end
    end

    assign root = root_reg[SQ_STG-1];

endmodule

`default_nettype wire

@@ sv/table_compound_sdf.sv @@
// Path: a point word accepted passes the 12-stage CORDIC and then two 13-stage root
// pipelines in series. Throughput: one point per cycle; the whole pipeline holds
// while the output word waits.
// Reset: rst_n async active low clears valid bits and loads register defaults.
`default_nettype none
`include "assert_macros.svh"

module table_compound_sdf
    import tcs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             pt_valid,
    output logic                  pt_ready,
    input  wire point_t           pt_data,
    output logic                  sdf_valid,
    input  wire logic             sdf_ready,
    output sdf_t                  sdf_data
);

    logic signed [COORD_W-1:0] center_x_reg;
    logic signed [COORD_W-1:0] center_y_reg;
    logic [REG_W-1:0]          table_height_reg;
    logic [REG_W-1:0]          top_width_reg;
    logic [REG_W-1:0]          top_depth_reg;
    logic signed [YAW_W-1:0]   yaw_angle_reg;
    logic [REG_W-1:0]          leg_radius_reg;
    logic [REG_W-1:0]          top_thickness_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            table_height_reg  <= REG_W'(49152);
            top_width_reg     <= REG_W'(65536);
            top_depth_reg     <= REG_W'(39322);
            yaw_angle_reg     <= '0;
            leg_radius_reg    <= REG_W'(1966);
            top_thickness_reg <= REG_W'(1966);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:      center_x_reg      <= cfg_data;
                REG_CENTER_Y:      center_y_reg      <= cfg_data;
                REG_TABLE_HEIGHT:  table_height_reg  <= cfg_data[REG_W-1:0];
                REG_TOP_WIDTH:     top_width_reg     <= cfg_data[REG_W-1:0];
                REG_TOP_DEPTH:     top_depth_reg     <= cfg_data[REG_W-1:0];
                REG_YAW_ANGLE:     yaw_angle_reg     <= cfg_data[YAW_W-1:0];
                REG_LEG_RADIUS:    leg_radius_reg    <= cfg_data[REG_W-1:0];
                REG_TOP_THICKNESS: top_thickness_reg <= cfg_data[REG_W-1:0];
            endcase
        end
    end

    // geometry derived from the registers
    logic signed [DIST_W-1:0] hw_s, hd_s, ht_s, r_s, zc_s, hgt_s, hh_s, cx_s, cy_s;

    assign hw_s  = DIST_W'({1'b0, top_width_reg[REG_W-1:1]});
    assign hd_s  = DIST_W'({1'b0, top_depth_reg[REG_W-1:1]});
    assign ht_s  = DIST_W'({1'b0, top_thickness_reg[REG_W-1:1]});
    assign r_s   = DIST_W'({1'b0, leg_radius_reg});
    assign zc_s  = DIST_W'({1'b0, table_height_reg}) - ht_s;
    assign hgt_s = DIST_W'({1'b0, table_height_reg}) - DIST_W'({1'b0, top_thickness_reg});
    assign hh_s  = hgt_s >>> 1;
    assign cx_s  = hw_s - r_s;
    assign cy_s  = hd_s - r_s;

    logic [LAT-1:0] vld_reg;
    logic           en;

    assign en        = !vld_reg[LAT-1] || sdf_ready;
    assign pt_ready  = en;
    assign sdf_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], pt_valid};
    end

    // shift into table frame, rotate by minus yaw
    rot_t                      rot1_reg;
    rot_t                      crd_reg [CRD_STG+1];
    logic signed [COORD_W-1:0] pz_dly_reg [PZ_N];
    logic signed [MUL_W-1:0]   mulx_reg, muly_reg;
    logic signed [LOC_W-1:0]   lx_reg, ly_reg;
    rot_t                      rot1_next;

    always_comb
    begin
        rot1_next.x  = CORD_W'(pt_data.point_x) - CORD_W'(center_x_reg);
        rot1_next.y  = CORD_W'(pt_data.point_y) - CORD_W'(center_y_reg);
        rot1_next.th = -(ANG_W'(yaw_angle_reg) <<< (ANG_FRAC - FRAC_W));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot1_reg      <= rot1_next;
            crd_reg[0]    <= pre_rot(pre_rot(rot1_reg));
            pz_dly_reg[0] <= pt_data.point_z;
            for (int i = 1; i < PZ_N; i++)
                pz_dly_reg[i] <= pz_dly_reg[i-1];
            mulx_reg <= crd_reg[CRD_STG].x * GAIN_Q;
            muly_reg <= crd_reg[CRD_STG].y * GAIN_Q;
            lx_reg   <= LOC_W'((mulx_reg + GAIN_RND) >>> GAIN_SH);
            ly_reg   <= LOC_W'((muly_reg + GAIN_RND) >>> GAIN_SH);
        end
    end

    for (genvar k = 0; k < CRD_STG; k++)
    begin : g_crd
        always_ff @(posedge clk)
        begin
            if (en)
                crd_reg[k+1] <= cordic_it(cordic_it(crd_reg[k], 5'(2 * k)), 5'(2 * k + 1));
        end
    end

    // component distances
    logic signed [DIST_W-1:0] lx_s, ly_s, pz_s;
    logic signed [DIST_W-1:0] dx_next, dy_next, dz_next, dv_next;
    logic signed [DIST_W-1:0] dlx_next [NUM_LEGS];
    logic signed [DIST_W-1:0] dly_next [NUM_LEGS];

    always_comb
    begin
        lx_s    = DIST_W'(lx_reg);
        ly_s    = DIST_W'(ly_reg);
        pz_s    = DIST_W'(pz_dly_reg[PZ_N-1]);
        dx_next = abs_d(lx_s) - hw_s;
        dy_next = abs_d(ly_s) - hd_s;
        dz_next = abs_d(pz_s - zc_s) - ht_s;
        dv_next = abs_d(pz_s - hh_s) - hh_s;
        for (int k = 0; k < NUM_LEGS; k++)
        begin
            dlx_next[k] = CORNER_NEG_X[k] ? lx_s + cx_s : lx_s - cx_s;
            dly_next[k] = CORNER_NEG_Y[k] ? ly_s + cy_s : ly_s - cy_s;
        end
    end

    logic signed [DIST_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DIST_W-1:0] dlx_reg [NUM_LEGS];
    logic signed [DIST_W-1:0] dly_reg [NUM_LEGS];
    logic signed [DIST_W-1:0] dv_dly_reg [DV_N];
    logic signed [DIST_W-1:0] mtop_dly_reg [MTOP_N];
    logic [SQ_W-1:0]          sqx_reg, sqy_reg, sqz_reg;
    logic [SQ_W-1:0]          sqlx_reg [NUM_LEGS];
    logic [SQ_W-1:0]          sqly_reg [NUM_LEGS];
    logic [SQ_IN_W-1:0]       rad1_top_reg;
    logic [SQ_IN_W-1:0]       rad1_leg_reg [NUM_LEGS];
    logic [COORD_W-1:0]       cdx, cdy, cdz;
    logic signed [DIST_W-1:0] mxy, mxyz;

    always_comb
    begin
        cdx  = clamp_u(dx_reg);
        cdy  = clamp_u(dy_reg);
        cdz  = clamp_u(dz_reg);
        mxy  = (dx_reg > dy_reg) ? dx_reg : dy_reg;
        mxyz = (dz_reg > mxy) ? dz_reg : mxy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            dz_reg        <= dz_next;
            dv_dly_reg[0] <= dv_next;
            for (int i = 1; i < DV_N; i++)
                dv_dly_reg[i] <= dv_dly_reg[i-1];
            sqx_reg         <= cdx * cdx;
            sqy_reg         <= cdy * cdy;
            sqz_reg         <= cdz * cdz;
            mtop_dly_reg[0] <= min0(mxyz);
            for (int i = 1; i < MTOP_N; i++)
                mtop_dly_reg[i] <= mtop_dly_reg[i-1];
            rad1_top_reg <= SQ_IN_W'(sqx_reg) + SQ_IN_W'(sqy_reg) + SQ_IN_W'(sqz_reg);
        end
    end

    for (genvar k = 0; k < NUM_LEGS; k++)
    begin : g_leg1
        logic [COORD_W-1:0] cax, cay;

        assign cax = clamp_u(abs_d(dlx_reg[k]));
        assign cay = clamp_u(abs_d(dly_reg[k]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dlx_reg[k]      <= dlx_next[k];
                dly_reg[k]      <= dly_next[k];
                sqlx_reg[k]     <= cax * cax;
                sqly_reg[k]     <= cay * cay;
                rad1_leg_reg[k] <= SQ_IN_W'(sqlx_reg[k]) + SQ_IN_W'(sqly_reg[k]);
            end
        end
    end

    // first roots: slab corner distance and leg radial distance
    logic [SQ_OUT_W-1:0] root1_top;
    logic [SQ_OUT_W-1:0] root1_leg [NUM_LEGS];

    tcs_isqrt u_sqrt_top (
        .clk  (clk),
        .en   (en),
        .rad  (rad1_top_reg),
        .root (root1_top)
    );

    logic signed [COORD_W-1:0] dtop_dly_reg [DTOP_N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dtop_dly_reg[0] <= sat_d($signed(SUM_W'(root1_top))
                                     + SUM_W'(mtop_dly_reg[MTOP_N-1]));
            for (int i = 1; i < DTOP_N; i++)
                dtop_dly_reg[i] <= dtop_dly_reg[i-1];
        end
    end

    logic signed [DIST_W-1:0]  dv_s;
    logic [COORD_W-1:0]        cdv;
    logic [SQ_W-1:0]           sqv_reg;
    logic signed [COORD_W-1:0] dleg_reg [NUM_LEGS];

    assign dv_s = dv_dly_reg[DV_N-1];
    assign cdv  = clamp_u(dv_s);

    always_ff @(posedge clk)
    begin
        if (en)
            sqv_reg <= cdv * cdv;
    end

    for (genvar k = 0; k < NUM_LEGS; k++)
    begin : g_leg2
        logic signed [DIST_W-1:0] rad_reg;
        logic signed [DIST_W-1:0] mleg_dly_reg [MLEG_N];
        logic [SQ_W-1:0]          sqr_reg;
        logic [SQ_IN_W-1:0]       rad2_reg;
        logic [SQ_OUT_W-1:0]      root2;
        logic [COORD_W-1:0]       crad;
        logic signed [DIST_W-1:0] mrv;

        tcs_isqrt u_sqrt_rad (
            .clk  (clk),
            .en   (en),
            .rad  (rad1_leg_reg[k]),
            .root (root1_leg[k])
        );

        tcs_isqrt u_sqrt_leg (
            .clk  (clk),
            .en   (en),
            .rad  (rad2_reg),
            .root (root2)
        );

        assign crad = clamp_u(rad_reg);
        assign mrv  = (rad_reg > dv_s) ? rad_reg : dv_s;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg         <= DIST_W'(root1_leg[k]) - r_s;
                sqr_reg         <= crad * crad;
                mleg_dly_reg[0] <= min0(mrv);
                for (int i = 1; i < MLEG_N; i++)
                    mleg_dly_reg[i] <= mleg_dly_reg[i-1];
                rad2_reg    <= SQ_IN_W'(sqr_reg) + SQ_IN_W'(sqv_reg);
                dleg_reg[k] <= sat_d($signed(SUM_W'(root2))
                                     + SUM_W'(mleg_dly_reg[MLEG_N-1]));
            end
        end
    end

    // first minimum over the five, lowest index wins ties
    logic signed [COORD_W-1:0] d_reg [NUM_LEGS+1];
    logic signed [COORD_W-1:0] best_a_reg, best_b_reg;
    part_t                     part_a_reg, part_b_reg;
    sdf_t                      sdf_data_reg;
    sdf_t                      sdf_data_next;
    logic signed [COORD_W-1:0] best_ab;
    part_t                     part_ab;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= dtop_dly_reg[DTOP_N-1];
            for (int k = 0; k < NUM_LEGS; k++)
                d_reg[k+1] <= dleg_reg[k];
            if (dleg_reg[0] < dtop_dly_reg[DTOP_N-1])
            begin
                best_a_reg <= dleg_reg[0];
                part_a_reg <= PART_LEG_A;
            end
            else
            begin
                best_a_reg <= dtop_dly_reg[DTOP_N-1];
                part_a_reg <= PART_TOP;
            end
            if (dleg_reg[2] < dleg_reg[1])
            begin
                best_b_reg <= dleg_reg[2];
                part_b_reg <= PART_LEG_C;
            end
            else
            begin
                best_b_reg <= dleg_reg[1];
                part_b_reg <= PART_LEG_B;
            end
            sdf_data_reg <= sdf_data_next;
        end
    end

    always_comb
    begin
        best_ab = best_a_reg;
        part_ab = part_a_reg;
        if (best_b_reg < best_a_reg)
        begin
            best_ab = best_b_reg;
            part_ab = part_b_reg;
        end
        sdf_data_next.dist_top     = d_reg[0];
        sdf_data_next.dist_leg_a   = d_reg[1];
        sdf_data_next.dist_leg_b   = d_reg[2];
        sdf_data_next.dist_leg_c   = d_reg[3];
        sdf_data_next.dist_leg_d   = d_reg[4];
        sdf_data_next.dist_union   = best_ab;
        sdf_data_next.nearest_part = part_ab;
        if (d_reg[4] < best_ab)
        begin
            sdf_data_next.dist_union   = d_reg[4];
            sdf_data_next.nearest_part = PART_LEG_D;
        end
    end

    assign sdf_data = sdf_data_reg;

    `ASSERT_NOW(a_union_min, !sdf_valid || ((sdf_data.dist_union <= sdf_data.dist_top) && (sdf_data.dist_union <= sdf_data.dist_leg_a) && (sdf_data.dist_union <= sdf_data.dist_leg_b) && (sdf_data.dist_union <= sdf_data.dist_leg_c) && (sdf_data.dist_union <= sdf_data.dist_leg_d)), "union distance above a part distance")
    `ASSERT_NOW(a_top_pick, !(sdf_valid && (sdf_data.nearest_part == PART_TOP)) || (sdf_data.dist_union == sdf_data.dist_top), "nearest part top but union differs")
    `ASSERT_NOW(a_leg_floor, !sdf_valid || (sdf_data.dist_leg_a >= -$signed({1'b0, leg_radius_reg})), "leg distance below minus radius")
    `ASSERT_NEXT(a_cfg_radius, cfg_wr_en && (cfg_index == REG_LEG_RADIUS), leg_radius_reg == $past(cfg_data[REG_W-1:0]), "leg radius write lost")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import tcs_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             pt_valid;
    logic             pt_ready;
    point_t           pt_data;
    logic             sdf_valid;
    logic             sdf_ready;
    sdf_t             sdf_data;

    table_compound_sdf dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pt_valid  (pt_valid),
        .pt_ready  (pt_ready),
        .pt_data   (pt_data),
        .sdf_valid (sdf_valid),
        .sdf_ready (sdf_ready),
        .sdf_data  (sdf_data)
    );

    localparam int CYCLE_LIMIT = 600000;
    localparam longint GAIN    = 64'sd163008219;
    localparam longint HALF_PI = 64'sd26353589;
    localparam longint ATAN [CORDIC_N] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    // table geometry as currently programmed
    longint cx, cy, height, width, depth, yaw, radius, thick;

    sdf_t   pending_dist[$];
    bit     failed;
    bit     steady;
    int     cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_dist(longint v);
        if (v <= 0)
            return 0;
        if (v > (64'sd1 << COORD_W) - 1)
            return (64'sd1 << COORD_W) - 1;
        return v;
    endfunction

    function automatic longint sat_dist(longint v);
        if (v > (64'sd1 << (COORD_W - 1)) - 1)
            return (64'sd1 << (COORD_W - 1)) - 1;
        if (v < -(64'sd1 << (COORD_W - 1)))
            return -(64'sd1 << (COORD_W - 1));
        return v;
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint norm3(longint a, longint b, longint c);
        longint s;
        longint root;
        longint rem;
        longint trial;
        s    = a * a + b * b + c * c;
        root = 0;
        rem  = 0;
        for (int i = 31; i >= 0; i--)
        begin
            rem   = (rem << 2) | ((s >> (2 * i)) & 3);
            trial = (root << 2) | 1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function automatic sdf_t table_distances(point_t p);
        longint x, y, th, t, xs, ys, lx, ly, pz, best;
        longint ht, dx, dy, dz, m, hh, r, dlx, dly, rad, dv;
        longint d [5];
        int     idx;
        sdf_t   e;
        x  = longint'(p.point_x) - cx;
        y  = longint'(p.point_y) - cy;
        pz = longint'(p.point_z);
        th = -yaw * 256;
        for (int i = 0; i < 2; i++)
        begin
            if (th > HALF_PI)
            begin
                t = x; x = -y; y = t; th = th - HALF_PI;
            end
            else if (th < -HALF_PI)
            begin
                t = x; x = y; y = -t; th = th + HALF_PI;
            end
        end
        for (int i = 0; i < CORDIC_N; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (th >= 0)
            begin
                x = x - ys; y = y + xs; th = th - ATAN[i];
            end
            else
            begin
                x = x + ys; y = y - xs; th = th + ATAN[i];
            end
        end
        lx = (x * GAIN + (64'sd1 << 27)) >>> 28;
        ly = (y * GAIN + (64'sd1 << 27)) >>> 28;

        ht = thick >> 1;
        dx = absl(lx) - (width >> 1);
        dy = absl(ly) - (depth >> 1);
        dz = absl(pz - (height - ht)) - ht;
        m  = dx > dy ? dx : dy;
        if (dz > m)
            m = dz;
        if (m > 0)
            m = 0;
        d[0] = sat_dist(norm3(clamp_dist(dx), clamp_dist(dy), clamp_dist(dz)) + m);

        r  = radius;
        hh = (height - thick) >>> 1;
        for (int k = 0; k < NUM_LEGS; k++)
        begin
            dlx = lx - (k == 1 || k == 2 ? -1 : 1) * ((width >> 1) - r);
            dly = ly - (k >= 2 ? -1 : 1) * ((depth >> 1) - r);
            rad = norm3(clamp_dist(absl(dlx)), clamp_dist(absl(dly)), 0) - r;
            dv  = absl(pz - hh) - hh;
            m   = rad > dv ? rad : dv;
            if (m > 0)
                m = 0;
            d[k + 1] = sat_dist(norm3(clamp_dist(rad), clamp_dist(dv), 0) + m);
        end

        best = d[0];
        idx  = 0;
        for (int k = 1; k < 5; k++)
        begin
            if (d[k] < best)
            begin
                best = d[k];
                idx  = k;
            end
        end
        e.dist_top     = d[0][COORD_W-1:0];
        e.dist_leg_a   = d[1][COORD_W-1:0];
        e.dist_leg_b   = d[2][COORD_W-1:0];
        e.dist_leg_c   = d[3][COORD_W-1:0];
        e.dist_leg_d   = d[4][COORD_W-1:0];
        e.dist_union   = best[COORD_W-1:0];
        e.nearest_part = part_t'(idx);
        return e;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    int ready_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sdf_ready  <= 1'b0;
            ready_left <= 0;
        end
        else if (steady)
            sdf_ready <= 1'b1;
        else if (ready_left == 0)
        begin
            if ($urandom_range(0, 1))
            begin
                sdf_ready  <= 1'b1;
                ready_left <= $urandom_range(1, 30);
            end
            else
            begin
                sdf_ready  <= 1'b0;
                ready_left <= pick_gap();
            end
        end
        else
            ready_left <= ready_left - 1;
    end

    task automatic check_field(string nm, logic [COORD_W-1:0] e, logic [COORD_W-1:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm,
                     $signed(e), $signed(a));
            failed = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        sdf_t e;
        if (rst_n && sdf_valid && sdf_ready)
        begin
            if (pending_dist.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, sdf_data);
                failed = 1'b1;
            end
            else
            begin
                e = pending_dist.pop_front();
                check_field("dist_top", e.dist_top, sdf_data.dist_top);
                check_field("dist_leg_a", e.dist_leg_a, sdf_data.dist_leg_a);
                check_field("dist_leg_b", e.dist_leg_b, sdf_data.dist_leg_b);
                check_field("dist_leg_c", e.dist_leg_c, sdf_data.dist_leg_c);
                check_field("dist_leg_d", e.dist_leg_d, sdf_data.dist_leg_d);
                check_field("dist_union", e.dist_union, sdf_data.dist_union);
                if (e.nearest_part !== sdf_data.nearest_part)
                begin
                    $display("%0t: nearest_part mismatch, expected %0d, actual %0d",
                             $time, e.nearest_part, sdf_data.nearest_part);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_point(point_t p);
        int gap;
        pt_valid <= 1'b1;
        pt_data  <= p;
        do
            @(posedge clk);
        while (!pt_ready);
        pending_dist = {pending_dist, table_distances(p)};
        gap = pick_gap();
        if (gap > 0)
        begin
            pt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        pt_valid <= 1'b0;
        @(posedge clk);
        while (pending_dist.size() != 0)
            @(posedge clk);
        repeat (LAT + 5) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CENTER_X:      cx = longint'($signed(v));
            REG_CENTER_Y:      cy = longint'($signed(v));
            REG_YAW_ANGLE:     yaw = longint'($signed(v[YAW_W-1:0]));
            REG_TABLE_HEIGHT:  height = longint'(v[REG_W-1:0]);
            REG_TOP_WIDTH:     width = longint'(v[REG_W-1:0]);
            REG_TOP_DEPTH:     depth = longint'(v[REG_W-1:0]);
            REG_LEG_RADIUS:    radius = longint'(v[REG_W-1:0]);
            REG_TOP_THICKNESS: thick = longint'(v[REG_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic set_table(int x, int y, int h, int w, int d, int a, int r, int t);
        drain();
        write_reg(REG_CENTER_X, CFG_W'(x));
        write_reg(REG_CENTER_Y, CFG_W'(y));
        write_reg(REG_TABLE_HEIGHT, CFG_W'(h));
        write_reg(REG_TOP_WIDTH, CFG_W'(w));
        write_reg(REG_TOP_DEPTH, CFG_W'(d));
        write_reg(REG_YAW_ANGLE, CFG_W'(a));
        write_reg(REG_LEG_RADIUS, CFG_W'(r));
        write_reg(REG_TOP_THICKNESS, CFG_W'(t));
    endtask

    function automatic point_t any_point();
        point_t p;
        p.point_x = COORD_W'($urandom);
        p.point_y = COORD_W'($urandom);
        p.point_z = COORD_W'($urandom);
        return p;
    endfunction

    // points around the programmed table centre, x and y offsets up to span, z from -span/2 to 3*span/2
    function automatic point_t near_point(int span);
        point_t p;
        p.point_x = COORD_W'(cx + $urandom_range(0, 2 * span) - span);
        p.point_y = COORD_W'(cy + $urandom_range(0, 2 * span) - span);
        p.point_z = COORD_W'($urandom_range(0, 2 * span) - span / 2);
        return p;
    endfunction

    function automatic point_t mk_point(int x, int y, int z);
        point_t p;
        p.point_x = COORD_W'(x);
        p.point_y = COORD_W'(y);
        p.point_z = COORD_W'(z);
        return p;
    endfunction

    task automatic run_random(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
                send_point(near_point(131072));
            else if (r < 8)
                send_point(near_point(16384));
            else
                send_point(any_point());
        end
    endtask

    task automatic test_defaults();
        steady = 1'b1;
        send_point(mk_point(0, 0, 0));
        send_point(mk_point(0, 0, 49152));
        send_point(mk_point(32768, 19661, 20000));
        send_point(mk_point(-32768, -19661, 0));
        send_point(mk_point(8388607, 8388607, 8388607));
        send_point(mk_point(-8388608, -8388608, -8388608));
        send_point(mk_point(8388607, -8388608, 0));
        send_point(mk_point(-8388608, 8388607, 49152));
        send_point(mk_point(30802, 17695, 23593));
        send_point(mk_point(-30802, 17695, 23593));
        send_point(mk_point(-30802, -17695, 23593));
        send_point(mk_point(30802, -17695, 23593));
        steady = 1'b0;
        drain();
    endtask

    task automatic test_extreme_tables();
        // yaw at both register extremes, huge and empty geometry
        set_table(8388607, -8388608, 8388607, 8388607, 8388607, -262144, 8388607, 8388607);
        send_point(mk_point(0, 0, 0));
        send_point(mk_point(8388607, -8388608, 8388607));
        send_point(mk_point(-8388608, 8388607, -8388608));
        run_random(15);
        set_table(-8388608, 8388607, 0, 0, 0, 262143, 0, 0);
        send_point(mk_point(-8388608, 8388607, 0));
        send_point(mk_point(0, 0, 0));
        run_random(15);
        // slab thicker than height, radius past half extent
        set_table(0, 0, 20000, 40000, 30000, 205887, 60000, 50000);
        run_random(40);
        set_table(0, 0, 65536, 65536, 65536, -205887, 1000, 2000);
        send_point(mk_point(0, 0, 0));
        run_random(40);
        drain();
    endtask

    task automatic test_random_tables();
        for (int ph = 0; ph < 6; ph++)
        begin
            set_table($urandom_range(0, 262144) - 131072, $urandom_range(0, 262144) - 131072,
                      $urandom_range(0, 131072), $urandom_range(0, 196608),
                      $urandom_range(0, 196608), $urandom_range(0, 411774) - 205887,
                      $urandom_range(0, 8192), $urandom_range(0, 16384));
            run_random(100);
        end
        set_table($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
        run_random(50);
        drain();
    endtask

    task automatic test_pause();
        run_random(30);
        pt_valid <= 1'b0;
        while (pending_dist.size() != 0)
            @(posedge clk);
        run_random(30);
        drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        pt_valid  = 1'b0;
        pt_data   = '0;
        failed    = 1'b0;
        steady    = 1'b0;
        cycles    = 0;
        cx = 0; cy = 0; height = 49152; width = 65536; depth = 39322;
        yaw = 0; radius = 1966; thick = 1966;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_extreme_tables();
        test_random_tables();
        test_pause();

        if (!failed && pending_dist.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/tcs_pkg.sv
sv/tcs_isqrt.sv
sv/table_compound_sdf.sv
tb/sv/tb.sv
